// ===== rtl/bol_pkg.sv =====
// Shared types and codes for the bounded ordered list and its cells.
package bol_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CountWidth = 5;

   typedef enum logic [1:0] {
      MODE_FRONT  = 2'd0,
      MODE_BACK   = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_FRONT,
      OP_BACK,
      OP_DELETE,
      OP_ROTATE
   } op_type;

   typedef struct packed {
      op_type                       op;
      logic signed [DataWidth-1:0]  key;
   } cell_cmd_type;

endpackage

// ===== rtl/bol_cell.sv =====
// One list position: a stored value, its occupied flag and the neighbor moves.
module bol_cell
   import bol_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cell_cmd_type                 cmd,
   input  logic signed [DataWidth-1:0]  left_value,
   input  logic                         left_occ,
   input  logic signed [DataWidth-1:0]  right_value,
   input  logic                         right_occ,
   input  logic signed [DataWidth-1:0]  head_value,
   input  logic                         hit_in,
   output logic                         hit_out,
   output logic signed [DataWidth-1:0]  value_out,
   output logic                         occ_out
);

   logic signed [DataWidth-1:0] value_ff, value_in;
   logic                        occ_ff, occ_in;
   logic                        match;

   assign match   = occ_ff && (value_ff == cmd.key);
   assign hit_out = hit_in || match;

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      case (cmd.op)
         OP_FRONT: begin
            value_in = left_value;
            occ_in   = left_occ;
         end
         OP_BACK: begin
            if (!occ_ff && left_occ) begin
               value_in = cmd.key;
               occ_in   = 1'b1;
            end
         end
         OP_DELETE: begin
            if (hit_out) begin
               value_in = right_value;
               occ_in   = right_occ;
            end
         end
         OP_ROTATE: begin
            if (occ_ff) begin
               value_in = right_occ ? right_value : head_value;
            end
         end
         default: begin
            value_in = value_ff;
            occ_in   = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign occ_out   = occ_ff;

endmodule

// ===== rtl/bounded_ordered_list.sv =====
// Bounded ordered list of signed 32-bit values built as a chain of cells.
//
// The request channel carries a mode and a value. Modes insert at the front,
// insert at the back, delete the first entry equal to the value, or read the
// whole list out front to back. Insert and delete give one response word with
// a status and the entry count. A readout gives one response word per entry,
// the final one marked by rsp_last, or a single word with status empty.
// Insert and delete are registered: the response word appears in the cycle
// after the request is accepted, and a new request may be accepted every
// cycle while the response side keeps up. During a readout the chain rotates
// by one position per cycle unless the receiver stalls, with cell 0 feeding
// the output, and the request channel stalls until the final word is loaded.
// When the receiver stalls, the response register holds its word and the
// request channel stalls with it. Synchronous reset empties the list and
// drops any pending response word.
module bounded_ordered_list
   import bol_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic signed [DataWidth-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic signed [DataWidth-1:0]  rsp_item,
   output logic                         rsp_last,
   output logic [CountWidth-1:0]        rsp_count
);

   localparam int unsigned LenWidth = $clog2(CAPACITY + 1);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                   state_ff, state_in;
   logic [LenWidth-1:0]         length_ff, length_in;
   logic [LenWidth-1:0]         left_ff, left_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic signed [DataWidth-1:0] rsp_item_ff, rsp_item_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [CountWidth-1:0]       rsp_count_ff, rsp_count_in;

   cell_cmd_type                cmd;
   logic                        out_free;
   logic                        accept;
   logic                        full;
   mode_type                    mode;

   logic signed [DataWidth-1:0] cell_value [CAPACITY];
   logic                        cell_occ   [CAPACITY];
   logic                        hit        [CAPACITY+1];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_READ) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (length_ff == LenWidth'(CAPACITY));
   assign mode      = mode_type'(req_mode);
   assign hit[0]    = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DataWidth-1:0] lv, rv;
      logic                        lo, ro;
      if (i == 0) begin : g_first
         assign lv = cmd.key;
         assign lo = 1'b1;
      end else begin : g_mid
         assign lv = cell_value[i-1];
         assign lo = cell_occ[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rv = cell_value[i];
         assign ro = 1'b0;
      end else begin : g_inner
         assign rv = cell_value[i+1];
         assign ro = cell_occ[i+1];
      end
      bol_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_value  (lv),
         .left_occ    (lo),
         .right_value (rv),
         .right_occ   (ro),
         .head_value  (cell_value[0]),
         .hit_in      (hit[i]),
         .hit_out     (hit[i+1]),
         .value_out   (cell_value[i]),
         .occ_out     (cell_occ[i])
      );
   end

   always_comb begin
      cmd.op  = OP_HOLD;
      cmd.key = req_value;

      state_in      = state_ff;
      length_in     = length_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;

      if (state_ff == ST_READ) begin
         if (out_free) begin
            cmd.op        = OP_ROTATE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_item_in   = cell_value[0];
            rsp_last_in   = (left_ff == LenWidth'(1));
            rsp_count_in  = CountWidth'(length_ff);
            left_in       = left_ff - LenWidth'(1);
            if (left_ff == LenWidth'(1)) begin
               state_in = ST_IDLE;
            end
         end
      end else if (accept) begin
         rsp_item_in = '0;
         rsp_last_in = 1'b1;
         case (mode)
            MODE_FRONT, MODE_BACK: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  cmd.op        = (mode == MODE_FRONT) ? OP_FRONT : OP_BACK;
                  rsp_status_in = STATUS_OK;
                  length_in     = length_ff + LenWidth'(1);
               end
            end
            MODE_DELETE: begin
               rsp_valid_in = 1'b1;
               cmd.op       = OP_DELETE;
               if (hit[CAPACITY]) begin
                  rsp_status_in = STATUS_OK;
                  length_in     = length_ff - LenWidth'(1);
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            MODE_READ: begin
               if (length_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  state_in = ST_READ;
                  left_in  = length_ff;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
         rsp_count_in = CountWidth'(length_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== rtl/bol_checker.sv =====
// Port-level checks for the bounded ordered list, bound to the top level.
module bol_checker
   import bol_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
)(
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic signed [DataWidth-1:0]  rsp_item,
   input logic                         rsp_last,
   input logic [CountWidth-1:0]        rsp_count
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item) && $stable(rsp_last))
      else $error("stalled response word changed");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last && (rsp_item == '0))
      else $error("error status word not final or carries an item");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_count == CountWidth'(CAPACITY)))
      else $error("full status with count below capacity");

endmodule

bind bounded_ordered_list bol_checker #(.CAPACITY(CAPACITY)) u_bol_checker (.*);
